// ===== design/jetp_pkg.sv =====
// jetp_pkg: widths, register indexes, reset values and the sideband record
// shared by the joint encoder position pipeline. No dependencies.

package jetp_pkg;

    localparam int ENC_W     = 32;              // assembled encoder value
    localparam int CFG_W     = 33;              // config write data
    localparam int CFG_IDX_W = 3;               // config register index
    localparam int ANG_W     = 32;              // Q16.16 angle
    localparam int NUM_W     = ENC_W + 3;       // signed encoder offset
    localparam int NMAG_W    = ENC_W + 2;       // offset magnitude
    localparam int HALF_W    = NMAG_W / 2;      // multiplier split point
    localparam int MMAG_W    = ANG_W;           // angle span magnitude
    localparam int DMAG_W    = CFG_W;           // encoder span magnitude
    localparam int PP_W      = HALF_W + MMAG_W; // partial product
    localparam int PROD_W    = NMAG_W + MMAG_W; // full product
    localparam int QUO_BITS  = 40;              // quotient bits below the cap
    localparam int QSAT_W    = QUO_BITS + 1;    // rounded or capped quotient
    localparam int QS_W      = QSAT_W + 1;      // signed quotient
    localparam int POS_W     = QS_W + 1;        // quotient plus lower angle

    localparam logic [ENC_W-1:0]  ROTARY_FAULT_SUM = 32'd131070;
    localparam logic [QSAT_W-1:0] QUO_CAP          = {1'b1, {QUO_BITS{1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENCODER_KIND     = 3'd0,
        CFG_ENCODER_LOW_END  = 3'd1,
        CFG_ENCODER_HIGH_END = 3'd2,
        CFG_ANGLE_LOWEST     = 3'd3,
        CFG_ANGLE_HIGHEST    = 3'd4
    } jetp_cfg_index_t;

    localparam logic            RST_ENCODER_KIND     = 1'b0;
    localparam logic [CFG_W-1:0] RST_ENCODER_LOW_END = 33'd0;
    localparam logic [CFG_W-1:0] RST_ENCODER_HIGH_END = 33'd65535;
    localparam logic [ANG_W-1:0] RST_ANGLE_LOWEST    = 32'd0;
    localparam logic [ANG_W-1:0] RST_ANGLE_HIGHEST   = 32'd65536;

    // Per-request status that rides alongside the arithmetic
    typedef struct packed {
        logic [ENC_W-1:0] ev;     // assembled encoder value
        logic             raw;    // pass value out unmapped
        logic             fault;  // rotary all-ones reading
        logic             neg;    // quotient sign
        logic             zero;   // encoder span is zero
        logic             sat;    // quotient reached the cap
    } jetp_side_t;

endpackage

// ===== design/jetp_div_pipe.sv =====
// jetp_div_pipe: pipelined restoring divider, one quotient bit per stage,
// with a cap test ahead of the first step. Depends on jetp_pkg.

module jetp_div_pipe
    import jetp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   prod_valid,
    input  logic [PROD_W-1:0]      product,
    input  logic [DMAG_W-1:0]      divisor,
    input  jetp_side_t             prod_side,
    output logic                   quo_valid,
    output logic [QUO_BITS-1:0]    quotient,
    output logic [DMAG_W-1:0]      remainder,
    output jetp_side_t             quo_side
);

    localparam int HEAD_W = PROD_W - QUO_BITS;

    logic                valid_reg [0:QUO_BITS];
    logic [DMAG_W-1:0]   rem_reg   [0:QUO_BITS];
    logic [QUO_BITS-1:0] pq_reg    [0:QUO_BITS];
    jetp_side_t          side_reg  [0:QUO_BITS];

    logic [DMAG_W-1:0] head;
    jetp_side_t        init_side;

    // The quotient reaches the cap exactly when the top of the product
    // is already at least the divisor.
    always_comb
    begin
        head          = DMAG_W'(product[PROD_W-1:QUO_BITS]);
        init_side     = prod_side;
        init_side.sat = (head >= divisor);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= prod_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= head;
            pq_reg[0]   <= product[QUO_BITS-1:0];
            side_reg[0] <= init_side;
        end
    end

    for (genvar k = 0; k < QUO_BITS; k++)
    begin : g_step
        logic [DMAG_W:0]   trial;
        logic              take;
        logic [DMAG_W:0]   diff;
        logic [DMAG_W-1:0] rem_next;
        logic [QUO_BITS-1:0] pq_next;

        always_comb
        begin
            trial    = {rem_reg[k], pq_reg[k][QUO_BITS-1]};
            take     = (trial >= {1'b0, divisor});
            diff     = trial - {1'b0, divisor};
            rem_next = take ? diff[DMAG_W-1:0] : trial[DMAG_W-1:0];
            // shift the dividend out and the quotient bit in
            pq_next  = {pq_reg[k][QUO_BITS-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= rem_next;
                pq_reg[k+1]   <= pq_next;
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign quo_valid = valid_reg[QUO_BITS];
    assign quotient  = pq_reg[QUO_BITS];
    assign remainder = rem_reg[QUO_BITS];
    assign quo_side  = side_reg[QUO_BITS];

endmodule

// ===== design/joint_encoder_to_position.sv =====
// joint_encoder_to_position: top level, frame assembly, scaling multiply,
// rounding and clamping around the pipelined divider. Depends on jetp_pkg.
//
//   channel    handshake                payload
//   frame      frame_valid / frame_stall frame_byte_0..3, raw_mode
//   position   position_valid / position_stall
//                                       joint_position, encoder_value, encoder_fault
//   cfg        cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One request per cycle enters while no finished result is held, and it passes
// 50 register stages: five ahead of the divider, its cap stage and 40 divider
// steps, and four after. Reset clears all valid bits and loads the register
// defaults. A stall on position while a result is held freezes the whole
// pipeline; one request taken during a stall waits in a skid register, and
// frame_stall is driven from that register.

module joint_encoder_to_position
    import jetp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  frame_valid,
    output logic                  frame_stall,
    input  logic [7:0]            frame_byte_0,
    input  logic [7:0]            frame_byte_1,
    input  logic [7:0]            frame_byte_2,
    input  logic [7:0]            frame_byte_3,
    input  logic                  raw_mode,

    output logic                  position_valid,
    input  logic                  position_stall,
    output logic signed [ANG_W-1:0] joint_position,
    output logic [ENC_W-1:0]      encoder_value,
    output logic                  encoder_fault,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    // configuration
    logic             kind_reg;
    logic [CFG_W-1:0] low_reg;
    logic [CFG_W-1:0] high_reg;
    logic [ANG_W-1:0] alow_reg;
    logic [ANG_W-1:0] ahigh_reg;

    logic [ANG_W:0]    m_diff_reg;
    logic [CFG_W:0]    d_diff_reg;
    logic [MMAG_W-1:0] m_mag_reg;
    logic              m_neg_reg;
    logic [DMAG_W-1:0] d_mag_reg;
    logic              d_neg_reg;
    logic              d_zero_reg;

    logic [ANG_W:0]    m_diff_next;
    logic [CFG_W:0]    d_diff_next;
    logic [ANG_W:0]    m_abs;
    logic [CFG_W:0]    d_abs;

    // skid and pipeline
    logic       en;
    logic       skid_full_reg;
    logic [7:0] skid_b0_reg, skid_b1_reg, skid_b2_reg, skid_b3_reg;
    logic       skid_raw_reg;

    logic       src_valid;
    logic [7:0] b0, b1, b2, b3;
    logic       src_raw;
    logic [ENC_W-1:0] ev_lin, ev_rot;
    jetp_side_t s1_side_next;

    logic              s1_valid_reg;
    jetp_side_t        s1_side_reg;
    logic              s2_valid_reg;
    jetp_side_t        s2_side_reg;
    logic [NUM_W-1:0]  s2_n_reg;
    logic [NUM_W-1:0]  s2_n_next;
    logic              s3_valid_reg;
    jetp_side_t        s3_side_reg;
    logic [NMAG_W-1:0] s3_n_mag_reg;
    logic              s3_n_neg_reg;
    logic [NUM_W-1:0]  n_abs;
    logic              s4_valid_reg;
    jetp_side_t        s4_side_reg;
    jetp_side_t        s4_side_next;
    logic [PP_W-1:0]   s4_pl_reg, s4_ph_reg;
    logic              s5_valid_reg;
    jetp_side_t        s5_side_reg;
    logic [PROD_W-1:0] s5_prod_reg;

    logic                dv_valid;
    logic [QUO_BITS-1:0] dv_quo;
    logic [DMAG_W-1:0]   dv_rem;
    jetp_side_t          dv_side;

    logic              r1_valid_reg;
    jetp_side_t        r1_side_reg;
    logic [QSAT_W-1:0] r1_q_reg;
    logic [QSAT_W-1:0] r1_q_next;
    logic              round_up;
    logic              r2_valid_reg;
    jetp_side_t        r2_side_reg;
    logic [QS_W-1:0]   r2_qs_reg;
    logic              r3_valid_reg;
    jetp_side_t        r3_side_reg;
    logic signed [POS_W-1:0] r3_pos_reg;

    logic signed [POS_W-1:0] ahigh_ext, alow_ext;
    logic [ANG_W-1:0]  pos_next;
    logic              fault_next;

    logic                   out_valid_reg;
    logic [ANG_W-1:0]       out_pos_reg;
    logic [ENC_W-1:0]       out_ev_reg;
    logic                   out_fault_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= RST_ENCODER_KIND;
            low_reg   <= RST_ENCODER_LOW_END;
            high_reg  <= RST_ENCODER_HIGH_END;
            alow_reg  <= RST_ANGLE_LOWEST;
            ahigh_reg <= RST_ANGLE_HIGHEST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ENCODER_KIND:     kind_reg  <= cfg_data[0];
                CFG_ENCODER_LOW_END:  low_reg   <= cfg_data;
                CFG_ENCODER_HIGH_END: high_reg  <= cfg_data;
                CFG_ANGLE_LOWEST:     alow_reg  <= cfg_data[ANG_W-1:0];
                CFG_ANGLE_HIGHEST:    ahigh_reg <= cfg_data[ANG_W-1:0];
                default:              ;
            endcase
        end
    end

    // Spans and their magnitudes, registered twice behind the config registers
    always_comb
    begin
        m_diff_next = {ahigh_reg[ANG_W-1], ahigh_reg} - {alow_reg[ANG_W-1], alow_reg};
        d_diff_next = {high_reg[CFG_W-1], high_reg} - {low_reg[CFG_W-1], low_reg};
        m_abs = m_diff_reg[ANG_W] ? ((ANG_W+1)'(0) - m_diff_reg) : m_diff_reg;
        d_abs = d_diff_reg[CFG_W] ? ((CFG_W+1)'(0) - d_diff_reg) : d_diff_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_diff_reg <= {1'b0, RST_ANGLE_HIGHEST} - {1'b0, RST_ANGLE_LOWEST};
            d_diff_reg <= {1'b0, RST_ENCODER_HIGH_END} - {1'b0, RST_ENCODER_LOW_END};
            m_mag_reg  <= RST_ANGLE_HIGHEST - RST_ANGLE_LOWEST;
            m_neg_reg  <= 1'b0;
            d_mag_reg  <= RST_ENCODER_HIGH_END - RST_ENCODER_LOW_END;
            d_neg_reg  <= 1'b0;
            d_zero_reg <= 1'b0;
        end
        else
        begin
            m_diff_reg <= m_diff_next;
            d_diff_reg <= d_diff_next;
            m_mag_reg  <= m_abs[MMAG_W-1:0];
            m_neg_reg  <= m_diff_reg[ANG_W];
            d_mag_reg  <= d_abs[DMAG_W-1:0];
            d_neg_reg  <= d_diff_reg[CFG_W];
            d_zero_reg <= (d_diff_reg == '0);
        end
    end

    // Advance everything unless a finished result is held
    assign en          = !out_valid_reg || !position_stall;
    assign frame_stall = skid_full_reg;

    always_comb
    begin
        src_valid = skid_full_reg || frame_valid;
        b0        = skid_full_reg ? skid_b0_reg  : frame_byte_0;
        b1        = skid_full_reg ? skid_b1_reg  : frame_byte_1;
        b2        = skid_full_reg ? skid_b2_reg  : frame_byte_2;
        b3        = skid_full_reg ? skid_b3_reg  : frame_byte_3;
        src_raw   = skid_full_reg ? skid_raw_reg : raw_mode;

        ev_lin = {b3, b2, b1, b0};
        ev_rot = {16'd0, b0, b1} + {16'd0, b2, b3};

        s1_side_next       = '0;
        s1_side_next.ev    = kind_reg ? ev_lin : ev_rot;
        s1_side_next.raw   = src_raw;
        s1_side_next.fault = !kind_reg && (ev_rot == ROTARY_FAULT_SUM);

        s2_n_next = {3'b000, s1_side_reg.ev} - {{(NUM_W-CFG_W){low_reg[CFG_W-1]}}, low_reg};
        n_abs     = s2_n_reg[NUM_W-1] ? (NUM_W'(0) - s2_n_reg) : s2_n_reg;

        s4_side_next      = s3_side_reg;
        s4_side_next.neg  = s3_n_neg_reg ^ m_neg_reg ^ d_neg_reg;
        s4_side_next.zero = d_zero_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            r1_valid_reg  <= 1'b0;
            r2_valid_reg  <= 1'b0;
            r3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                skid_full_reg <= 1'b0;
                s1_valid_reg  <= src_valid;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                s4_valid_reg  <= s3_valid_reg;
                s5_valid_reg  <= s4_valid_reg;
                r1_valid_reg  <= dv_valid;
                r2_valid_reg  <= r1_valid_reg;
                r3_valid_reg  <= r2_valid_reg;
                out_valid_reg <= r3_valid_reg;
            end
            else if (frame_valid && !skid_full_reg)
            begin
                skid_full_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!en && !skid_full_reg)
        begin
            skid_b0_reg  <= frame_byte_0;
            skid_b1_reg  <= frame_byte_1;
            skid_b2_reg  <= frame_byte_2;
            skid_b3_reg  <= frame_byte_3;
            skid_raw_reg <= raw_mode;
        end
        if (en)
        begin
            s1_side_reg  <= s1_side_next;
            s2_side_reg  <= s1_side_reg;
            s2_n_reg     <= s2_n_next;
            s3_side_reg  <= s2_side_reg;
            s3_n_mag_reg <= n_abs[NMAG_W-1:0];
            s3_n_neg_reg <= s2_n_reg[NUM_W-1];
            s4_side_reg  <= s4_side_next;
            s4_pl_reg    <= PP_W'(s3_n_mag_reg[HALF_W-1:0]) * PP_W'(m_mag_reg);
            s4_ph_reg    <= PP_W'(s3_n_mag_reg[NMAG_W-1:HALF_W]) * PP_W'(m_mag_reg);
            s5_side_reg  <= s4_side_reg;
            s5_prod_reg  <= PROD_W'(s4_pl_reg) + {s4_ph_reg, {HALF_W{1'b0}}};
        end
    end

    jetp_div_pipe u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .prod_valid (s5_valid_reg),
        .product    (s5_prod_reg),
        .divisor    (d_mag_reg),
        .prod_side  (s5_side_reg),
        .quo_valid  (dv_valid),
        .quotient   (dv_quo),
        .remainder  (dv_rem),
        .quo_side   (dv_side)
    );

    // Round half away from zero on the magnitude, then apply sign and offset
    always_comb
    begin
        round_up  = ({dv_rem, 1'b0} >= {1'b0, d_mag_reg});
        r1_q_next = dv_side.sat ? QUO_CAP : ({1'b0, dv_quo} + QSAT_W'(round_up));

        alow_ext  = {{(POS_W-ANG_W){alow_reg[ANG_W-1]}}, alow_reg};
        ahigh_ext = {{(POS_W-ANG_W){ahigh_reg[ANG_W-1]}}, ahigh_reg};

        // upper limit wins when the limits are swapped
        if (r3_pos_reg >= ahigh_ext)
        begin
            pos_next = ahigh_reg;
        end
        else if (r3_pos_reg <= alow_ext)
        begin
            pos_next = alow_reg;
        end
        else
        begin
            pos_next = r3_pos_reg[ANG_W-1:0];
        end
        fault_next = r3_side_reg.fault;

        if (r3_side_reg.raw)
        begin
            pos_next = '0;
        end
        else if (r3_side_reg.zero)
        begin
            pos_next   = alow_reg;
            fault_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_side_reg   <= dv_side;
            r1_q_reg      <= r1_q_next;
            r2_side_reg   <= r1_side_reg;
            r2_qs_reg     <= r1_side_reg.neg ? (QS_W'(0) - {1'b0, r1_q_reg})
                                             : {1'b0, r1_q_reg};
            r3_side_reg   <= r2_side_reg;
            r3_pos_reg    <= $signed({r2_qs_reg[QS_W-1], r2_qs_reg}) + alow_ext;
            out_pos_reg   <= pos_next;
            out_ev_reg    <= r3_side_reg.ev;
            out_fault_reg <= fault_next;
        end
    end

    assign position_valid = out_valid_reg;
    assign joint_position = out_pos_reg;
    assign encoder_value  = out_ev_reg;
    assign encoder_fault  = out_fault_reg;

endmodule

// ===== design/jetp_checker.sv =====
// jetp_checker: port-level checks on the joint encoder position block and
// the bind that attaches them. No package dependency.

module jetp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        frame_valid,
    input logic        frame_stall,
    input logic        position_valid,
    input logic        position_stall,
    input logic [31:0] joint_position,
    input logic [31:0] encoder_value,
    input logic        encoder_fault
);

    // Nothing pending and nothing offered once reset has been held over a clock
    a_reset_clear: assert property (@(posedge clk)
        !rst_n ##1 !rst_n |-> !position_valid && !frame_stall)
        else $error("outputs active during reset");

    // A held result keeps its value until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        position_valid && position_stall |=>
            position_valid && $stable(joint_position) &&
            $stable(encoder_value) && $stable(encoder_fault))
        else $error("held result changed");

    // Input backpressure only follows a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(frame_stall) |-> $past(position_valid && position_stall) &&
            $past(frame_valid))
        else $error("frame stall without a blocked result");

    // Once the result side moves, the waiting request drains at once
    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        frame_stall && !(position_valid && position_stall) |=> !frame_stall)
        else $error("frame stall held after result side moved");

endmodule

bind joint_encoder_to_position jetp_checker u_jetp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .frame_valid    (frame_valid),
    .frame_stall    (frame_stall),
    .position_valid (position_valid),
    .position_stall (position_stall),
    .joint_position (joint_position),
    .encoder_value  (encoder_value),
    .encoder_fault  (encoder_fault)
);

// ===== tb/sv/jetp_position_checker.sv =====
`timescale 1ns / 1ps
// jetp_position_checker: follows the frame, position and cfg channels of
// joint_encoder_to_position, predicts each position result and compares in order.
// Depends on jetp_pkg.

module jetp_position_checker
    import jetp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    frame_valid,
    input  logic                    frame_stall,
    input  logic [7:0]              frame_byte_0,
    input  logic [7:0]              frame_byte_1,
    input  logic [7:0]              frame_byte_2,
    input  logic [7:0]              frame_byte_3,
    input  logic                    raw_mode,

    input  logic                    position_valid,
    input  logic                    position_stall,
    input  logic signed [ANG_W-1:0] joint_position,
    input  logic [ENC_W-1:0]        encoder_value,
    input  logic                    encoder_fault,

    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,

    output int                      mismatches,
    output int                      pending
);

    typedef struct packed {
        logic signed [ANG_W-1:0] position;
        logic [ENC_W-1:0]        value;
        logic                    fault;
    } position_result_t;

    // Shadow of the scaling registers, loaded with the reset values
    logic   kind_q     = RST_ENCODER_KIND;
    longint low_end_q  = $signed(RST_ENCODER_LOW_END);
    longint high_end_q = $signed(RST_ENCODER_HIGH_END);
    longint angle_lo_q = $signed(RST_ANGLE_LOWEST);
    longint angle_hi_q = $signed(RST_ANGLE_HIGHEST);

    position_result_t expected_positions[$];
    position_result_t want;
    logic             bad;

    function automatic position_result_t predict_position(
        input logic [7:0] b0,
        input logic [7:0] b1,
        input logic [7:0] b2,
        input logic [7:0] b3,
        input logic       raw
    );
        position_result_t r;
        longint           ev;
        longint           num;
        longint           gain;
        longint           span;
        longint           q;
        longint           pos;
        logic [63:0]      num_mag;
        logic [63:0]      gain_mag;
        logic [63:0]      span_mag;
        logic [127:0]     prod;
        logic [127:0]     den;
        logic [127:0]     quo;
        logic [127:0]     rem;
        logic             neg;
        r = '0;
        pos = 0;
        if (kind_q)
        begin
            ev = {32'd0, b3, b2, b1, b0};
        end
        else
        begin
            ev = {48'd0, b0, b1} + {48'd0, b2, b3};
            r.fault = (ev[ENC_W-1:0] == ROTARY_FAULT_SUM);
        end
        if (!raw)
        begin
            span = high_end_q - low_end_q;
            if (span == 0)
            begin
                pos = angle_lo_q;
                r.fault = 1'b1;
            end
            else
            begin
                num  = ev - low_end_q;
                gain = angle_hi_q - angle_lo_q;
                neg  = ((num < 0) != (gain < 0)) != (span < 0);
                num_mag  = (num < 0) ? -num : num;
                gain_mag = (gain < 0) ? -gain : gain;
                span_mag = (span < 0) ? -span : span;
                prod = {64'd0, num_mag} * {64'd0, gain_mag};
                den  = {64'd0, span_mag};
                quo  = prod / den;
                rem  = prod % den;
                // Saturate oversized quotients, otherwise round half away from zero
                if (quo >= 128'(QUO_CAP))
                begin
                    q = longint'(QUO_CAP);
                end
                else
                begin
                    q = longint'(quo[63:0]);
                    if ((rem << 1) >= den)
                        q = q + 1;
                end
                if (neg)
                    q = -q;
                pos = q + angle_lo_q;
                // Upper limit wins when the limits are swapped
                if (pos >= angle_hi_q)
                    pos = angle_hi_q;
                else if (pos <= angle_lo_q)
                    pos = angle_lo_q;
            end
        end
        r.position = pos[ANG_W-1:0];
        r.value    = ev[ENC_W-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (position_valid && !position_stall)
            begin
                if (expected_positions.size() == 0)
                begin
                    $display("%0t: unexpected result: position %0d value %0d fault %0d",
                             $time, joint_position, encoder_value, encoder_fault);
                    mismatches++;
                end
                else
                begin
                    want = expected_positions.pop_front();
                    bad = 1'b0;
                    if (joint_position !== want.position)
                    begin
                        $display("%0t: joint_position expected %0d actual %0d",
                                 $time, want.position, joint_position);
                        bad = 1'b1;
                    end
                    if (encoder_value !== want.value)
                    begin
                        $display("%0t: encoder_value expected %0d actual %0d",
                                 $time, want.value, encoder_value);
                        bad = 1'b1;
                    end
                    if (encoder_fault !== want.fault)
                    begin
                        $display("%0t: encoder_fault expected %0d actual %0d",
                                 $time, want.fault, encoder_fault);
                        bad = 1'b1;
                    end
                    if (bad)
                        mismatches++;
                end
            end

            if (frame_valid && !frame_stall)
                expected_positions.push_back(predict_position(frame_byte_0, frame_byte_1,
                                                              frame_byte_2, frame_byte_3,
                                                              raw_mode));

            if (cfg_valid && cfg_ready)
            begin
                case (jetp_cfg_index_t'(cfg_index))
                    CFG_ENCODER_KIND:     kind_q     = cfg_data[0];
                    CFG_ENCODER_LOW_END:  low_end_q  = $signed(cfg_data);
                    CFG_ENCODER_HIGH_END: high_end_q = $signed(cfg_data);
                    CFG_ANGLE_LOWEST:     angle_lo_q = $signed(cfg_data[ANG_W-1:0]);
                    CFG_ANGLE_HIGHEST:    angle_hi_q = $signed(cfg_data[ANG_W-1:0]);
                    default:              ;
                endcase
            end

            pending = expected_positions.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// tb: drives encoder frames and register writes into joint_encoder_to_position
// under changing idle patterns. Depends on jetp_pkg and jetp_position_checker.

module tb
    import jetp_pkg::*;
();

    localparam int     CYCLE_LIMIT   = 200000;
    localparam int     SETTINGS_RUN  = 12;
    localparam int     FRAMES_EACH   = 50;
    localparam longint ENC_END_MIN   = -64'sd4294967296;
    localparam longint ENC_END_MAX   = 64'sd4294967295;
    localparam longint ANGLE_MIN     = -64'sd2147483648;
    localparam longint ANGLE_MAX     = 64'sd2147483647;

    logic                    clk            = 1'b0;
    logic                    rst_n          = 1'b0;
    logic                    frame_valid    = 1'b0;
    logic                    frame_stall;
    logic [7:0]              frame_byte_0   = '0;
    logic [7:0]              frame_byte_1   = '0;
    logic [7:0]              frame_byte_2   = '0;
    logic [7:0]              frame_byte_3   = '0;
    logic                    raw_mode       = 1'b0;
    logic                    position_valid;
    logic                    position_stall = 1'b0;
    logic signed [ANG_W-1:0] joint_position;
    logic [ENC_W-1:0]        encoder_value;
    logic                    encoder_fault;
    logic                    cfg_valid      = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index      = '0;
    logic [CFG_W-1:0]        cfg_data       = '0;

    int mismatches;
    int pending;
    int sender_idle_pct = 10;
    int stall_pct       = 80;
    int cycle_count     = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    joint_encoder_to_position DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame_valid    (frame_valid),
        .frame_stall    (frame_stall),
        .frame_byte_0   (frame_byte_0),
        .frame_byte_1   (frame_byte_1),
        .frame_byte_2   (frame_byte_2),
        .frame_byte_3   (frame_byte_3),
        .raw_mode       (raw_mode),
        .position_valid (position_valid),
        .position_stall (position_stall),
        .joint_position (joint_position),
        .encoder_value  (encoder_value),
        .encoder_fault  (encoder_fault),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    jetp_position_checker position_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame_valid    (frame_valid),
        .frame_stall    (frame_stall),
        .frame_byte_0   (frame_byte_0),
        .frame_byte_1   (frame_byte_1),
        .frame_byte_2   (frame_byte_2),
        .frame_byte_3   (frame_byte_3),
        .raw_mode       (raw_mode),
        .position_valid (position_valid),
        .position_stall (position_stall),
        .joint_position (joint_position),
        .encoder_value  (encoder_value),
        .encoder_fault  (encoder_fault),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    always @(negedge clk)
    begin
        if (rst_n)
            position_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the request is taken
    task automatic send_frame(
        input logic [7:0] b0,
        input logic [7:0] b1,
        input logic [7:0] b2,
        input logic [7:0] b3,
        input logic       raw
    );
        while ($urandom_range(99) < sender_idle_pct)
        begin
            frame_valid <= 1'b0;
            @(negedge clk);
        end
        frame_valid  <= 1'b1;
        frame_byte_0 <= b0;
        frame_byte_1 <= b1;
        frame_byte_2 <= b2;
        frame_byte_3 <= b3;
        raw_mode     <= raw;
        do
            @(posedge clk);
        while (frame_stall);
        @(negedge clk);
    endtask

    task automatic send_random_frame();
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic       raw;
        b0 = 8'($urandom_range(255));
        b1 = 8'($urandom_range(255));
        b2 = 8'($urandom_range(255));
        b3 = 8'($urandom_range(255));
        case ($urandom_range(9))
            0:       {b0, b1, b2, b3} = 32'hFFFF_FFFF;
            1:       {b0, b1, b2, b3} = 32'h0000_0000;
            2:       {b0, b1, b2, b3} = 32'hFFFF_FFFE;
            3:       {b2, b3} = 16'hFFFF;
            default: ;
        endcase
        raw = ($urandom_range(3) == 0);
        send_frame(b0, b1, b2, b3, raw);
    endtask

    // Hold off new frames until every position result has come back
    task automatic drain_positions();
        frame_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input jetp_cfg_index_t idx, input longint value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic load_setting(
        input logic   kind,
        input longint low,
        input longint high,
        input longint alo,
        input longint ahi
    );
        drain_positions();
        write_reg(CFG_ENCODER_KIND, longint'(kind));
        write_reg(CFG_ENCODER_LOW_END, low);
        write_reg(CFG_ENCODER_HIGH_END, high);
        write_reg(CFG_ANGLE_LOWEST, alo);
        write_reg(CFG_ANGLE_HIGHEST, ahi);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_random_setting();
        logic        kind;
        logic [32:0] w;
        longint      low;
        longint      high;
        longint      alo;
        longint      ahi;
        kind = 1'($urandom_range(1));
        case ($urandom_range(3))
            0:
            begin
                w = 33'({$urandom, $urandom});
                low = $signed(w);
                w = 33'({$urandom, $urandom});
                high = $signed(w);
            end
            1:
            begin
                low  = longint'($urandom_range(2000));
                high = low + longint'($urandom_range(kind ? 2000000 : 140000));
            end
            2:
            begin
                // one-count span drives quotients into the cap
                low  = longint'($urandom_range(1000));
                high = $urandom_range(1) ? low + 1 : low - 1;
            end
            default:
            begin
                low  = kind ? 64'sd4294967295 : 64'sd131070;
                high = longint'($urandom_range(100));
            end
        endcase
        case ($urandom_range(2))
            0:
            begin
                alo = $signed(32'($urandom));
                ahi = $signed(32'($urandom));
            end
            1:
            begin
                alo = -(longint'($urandom_range(360)) << 16);
                ahi = longint'($urandom_range(360)) << 16;
            end
            default:
            begin
                alo = $signed(32'($urandom));
                ahi = alo;
            end
        endcase
        load_setting(kind, low, high, alo, ahi);
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset scaling: rotary, 0..65535 onto 0..1.0
        send_frame(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFE, 1'b0);
        send_frame(8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0);
        send_frame(8'h7F, 8'hFF, 8'h00, 8'h01, 1'b0);
        send_frame(8'h80, 8'h00, 8'h80, 8'h00, 1'b0);
        send_frame(8'h00, 8'h01, 8'h00, 8'h00, 1'b0);
        send_frame(8'h12, 8'h34, 8'h56, 8'h78, 1'b1);
        send_frame(8'h00, 8'h80, 8'h00, 8'h00, 1'b0);

        for (int s = 0; s < SETTINGS_RUN; s++)
        begin
            if (s == 4)
            begin
                sender_idle_pct = 80;
                stall_pct       = 10;
            end
            else if (s == 8)
            begin
                sender_idle_pct = 0;
                stall_pct       = 0;
            end

            case (s)
                0:
                begin
                    load_setting(1'b1, 0, ENC_END_MAX >>> 1, ANGLE_MIN, ANGLE_MAX);
                    send_frame(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
                    send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
                    send_frame(8'h00, 8'h00, 8'h00, 8'h80, 1'b0);
                    send_frame(8'hFF, 8'hFF, 8'hFF, 8'h7F, 1'b1);
                end
                1:
                begin
                    // swapped angle limits over the widest encoder span
                    load_setting(1'b0, ENC_END_MIN, ENC_END_MAX, ANGLE_MAX, ANGLE_MIN);
                    send_frame(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
                    send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
                end
                2:
                begin
                    load_setting(1'b0, 5000, 5000, -(64'sd45 << 16), 64'sd45 << 16);
                    send_frame(8'h01, 8'h02, 8'h03, 8'h04, 1'b0);
                    send_frame(8'h01, 8'h02, 8'h03, 8'h04, 1'b1);
                    send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
                end
                3:
                    load_setting(1'b0, 131070, 0, -(64'sd90 << 16), 64'sd90 << 16);
                4:
                    load_setting(1'b1, 100, 101, ANGLE_MIN, ANGLE_MAX);
                5:
                    load_setting(1'b1, 0, ENC_END_MAX, ANGLE_MIN, ANGLE_MAX);
                default:
                    load_random_setting();
            endcase

            for (int n = 0; n < FRAMES_EACH; n++)
            begin
                if (s == 1 && n == FRAMES_EACH / 2)
                    drain_positions();
                send_random_frame();
            end
        end

        drain_positions();
        repeat (60) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== joint_encoder_to_position.f =====
design/jetp_pkg.sv
design/jetp_div_pipe.sv
design/joint_encoder_to_position.sv
design/jetp_checker.sv
tb/sv/jetp_position_checker.sv
tb/sv/tb.sv
